/* src/ihc_pkg.sv */
// Shared types and constants for the interval histogram counter.
`timescale 1ns / 1ps
package ihc_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COUNT_W       = 16;
  localparam int MAX_BINS      = 4;
  localparam int BIN_IDX_W     = 2;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;

  localparam int NUM_BINS_DEF    = 4;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
  } ihc_in_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_hit;
    logic                 in_range;
    logic [COUNT_W-1:0]   count_bin0;
    logic [COUNT_W-1:0]   count_bin1;
    logic [COUNT_W-1:0]   count_bin2;
    logic [COUNT_W-1:0]   count_bin3;
    logic [COUNT_W-1:0]   miss_count;
  } ihc_out_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [BIN_IDX_W-1:0] which;
  } ihc_ctl_t;

endpackage

/* src/ihc_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
`timescale 1ns / 1ps
interface ihc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/ihc_bin_cell.sv */
// One bin of the chain: holds its counter and passes the sample token on.
`timescale 1ns / 1ps
module ihc_bin_cell #(
  parameter int INDEX       = 0,
  parameter int NUM_BINS    = ihc_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS  = ihc_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = ihc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [ihc_pkg::CFG_DATA_W-1:0] low_bound,
  input  logic [ihc_pkg::CFG_DATA_W-1:0] high_bound,
  input  logic [SAMPLE_BITS-1:0]       sample_in,
  input  ihc_pkg::ihc_ctl_t            ctl_in,
  input  logic [COUNT_BITS-1:0]        counts_in [NUM_BINS],
  output logic [SAMPLE_BITS-1:0]       sample_out,
  output ihc_pkg::ihc_ctl_t            ctl_out,
  output logic [COUNT_BITS-1:0]        counts_out [NUM_BINS]
);

  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] hi;
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          match;
  logic [COUNT_BITS-1:0]         count;
  logic [COUNT_BITS-1:0]         count_next;
  ihc_pkg::ihc_ctl_t             ctl_next;

  if (SAMPLE_BITS <= ihc_pkg::CFG_DATA_W) begin : g_narrow
    assign lo = low_bound[SAMPLE_BITS-1:0];
    assign hi = high_bound[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign lo = {{(SAMPLE_BITS - ihc_pkg::CFG_DATA_W){1'b0}}, low_bound};
    assign hi = {{(SAMPLE_BITS - ihc_pkg::CFG_DATA_W){1'b0}}, high_bound};
  end

  assign x = sample_in;

  always_comb begin
    match = ctl_in.valid && !ctl_in.hit && (hi >= lo) && (x >= lo) && (x <= hi);
    count_next = count;
    if (match && (count != {COUNT_BITS{1'b1}})) begin
      count_next = count + 1'b1;
    end
    ctl_next = ctl_in;
    if (match) begin
      ctl_next.hit   = 1'b1;
      ctl_next.which = ihc_pkg::BIN_IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      count   <= count_next;
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out <= sample_in;
      for (int k = 0; k < NUM_BINS; k++) begin
        counts_out[k] <= (k == INDEX) ? count_next : counts_in[k];
      end
    end
  end

endmodule

/* src/ihc_miss_cell.sv */
// Last cell of the chain: out-of-range counter and the result register.
`timescale 1ns / 1ps
module ihc_miss_cell #(
  parameter int NUM_BINS   = ihc_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = ihc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ihc_pkg::ihc_ctl_t     ctl_in,
  input  logic [COUNT_BITS-1:0] counts_in [NUM_BINS],
  output logic                  out_valid,
  output ihc_pkg::ihc_out_t     out_data
);

  logic [COUNT_BITS-1:0]       miss;
  logic [COUNT_BITS-1:0]       miss_next;
  logic [ihc_pkg::COUNT_W-1:0] cnt16 [ihc_pkg::MAX_BINS];
  logic [ihc_pkg::COUNT_W-1:0] miss16;

  for (genvar b = 0; b < ihc_pkg::MAX_BINS; b++) begin : g_cnt
    if (b >= NUM_BINS) begin : g_absent
      assign cnt16[b] = '0;
    end else if (COUNT_BITS >= ihc_pkg::COUNT_W) begin : g_trunc
      assign cnt16[b] = counts_in[b][ihc_pkg::COUNT_W-1:0];
    end else begin : g_ext
      assign cnt16[b] = {{(ihc_pkg::COUNT_W - COUNT_BITS){1'b0}}, counts_in[b]};
    end
  end

  if (COUNT_BITS >= ihc_pkg::COUNT_W) begin : g_miss_trunc
    assign miss16 = miss_next[ihc_pkg::COUNT_W-1:0];
  end else begin : g_miss_ext
    assign miss16 = {{(ihc_pkg::COUNT_W - COUNT_BITS){1'b0}}, miss_next};
  end

  always_comb begin
    miss_next = miss;
    if (ctl_in.valid && !ctl_in.hit && (miss != {COUNT_BITS{1'b1}})) begin
      miss_next = miss + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      miss      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      miss      <= miss_next;
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.bin_hit    <= ctl_in.hit ? ctl_in.which : '0;
      out_data.in_range   <= ctl_in.hit;
      out_data.count_bin0 <= cnt16[0];
      out_data.count_bin1 <= cnt16[1];
      out_data.count_bin2 <= cnt16[2];
      out_data.count_bin3 <= cnt16[3];
      out_data.miss_count <= miss16;
    end
  end

endmodule

/* src/interval_histogram_counter.sv */
// Interval histogram counter: chain of bin cells followed by the miss cell.
//
// Usage: each transfer on the samples channel carries one signed sample.
// The sample walks a chain of NUM_BINS bin cells, one cell per cycle while the chain advances; the
// first enabled bin whose inclusive interval holds it raises its counter.
// A final cell counts samples that no bin took and registers the result.
// Each result transfer gives the bin hit, the in-range flag, all bin counts
// and the miss count as they stand after that sample.
// Result valid is registered in the miss cell, behind the register of every bin cell;
// one sample is taken every cycle while results are drained.
// Bin bounds are written through cfg_we/cfg_index/cfg_data; the user must write them only while idle,
// which the block itself leaves unchecked; indexes beyond the register list are ignored.
// Reset clears all counters and the chain, sets every low bound to zero and
// every high bound to minus one, which leaves all bins disabled.
// When the receiver stalls with a result pending, the whole chain holds and
// samples.ready drops until that result is taken.
`timescale 1ns / 1ps
module interval_histogram_counter #(
  parameter int NUM_BINS    = ihc_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS  = ihc_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = ihc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ihc_stream_if.sink                     samples,
  ihc_stream_if.source                   results,
  input  logic                           cfg_we,
  input  logic [ihc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ihc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int REG_SEL_W = $clog2(ihc_pkg::NUM_REGS);

  logic [ihc_pkg::CFG_DATA_W-1:0] bounds [ihc_pkg::NUM_REGS];
  logic                           adv;
  logic [SAMPLE_BITS-1:0]         sample_s [NUM_BINS+1];
  ihc_pkg::ihc_ctl_t              ctl_s [NUM_BINS+1];
  logic [COUNT_BITS-1:0]          counts_s [NUM_BINS+1][NUM_BINS];
  ihc_pkg::ihc_in_t               in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ihc_pkg::NUM_REGS; r++) begin
        bounds[r] <= (r % 2 == 1) ? {ihc_pkg::CFG_DATA_W{1'b1}} : '0;
      end
    end else if (cfg_we && (cfg_index < ihc_pkg::CFG_IDX_W'(ihc_pkg::NUM_REGS))) begin
      bounds[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign adv           = !results.valid || results.ready;
  assign samples.ready = adv;
  assign in_data       = samples.data;

  if (SAMPLE_BITS <= ihc_pkg::SAMPLE_W) begin : g_narrow
    assign sample_s[0] = in_data.sample_value[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign sample_s[0] = {{(SAMPLE_BITS - ihc_pkg::SAMPLE_W){1'b0}}, in_data.sample_value};
  end

  assign ctl_s[0]    = '{valid: samples.valid, hit: 1'b0, which: '0};
  assign counts_s[0] = '{default: '0};

  for (genvar j = 0; j < NUM_BINS; j++) begin : g_bin
    ihc_bin_cell #(
      .INDEX       (j),
      .NUM_BINS    (NUM_BINS),
      .COUNT_BITS  (COUNT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .low_bound  (bounds[2*j]),
      .high_bound (bounds[2*j+1]),
      .sample_in  (sample_s[j]),
      .ctl_in     (ctl_s[j]),
      .counts_in  (counts_s[j]),
      .sample_out (sample_s[j+1]),
      .ctl_out    (ctl_s[j+1]),
      .counts_out (counts_s[j+1])
    );
  end

  ihc_miss_cell #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_miss (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (ctl_s[NUM_BINS]),
    .counts_in (counts_s[NUM_BINS]),
    .out_valid (results.valid),
    .out_data  (results.data)
  );

endmodule

/* verif/ihc_result_checker.sv */
// Result checker for the interval histogram counter: predicts each result and compares it.
`timescale 1ns / 1ps
module ihc_result_checker
  import ihc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  ihc_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  ihc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  logic signed [SAMPLE_W-1:0] bound_q [NUM_REGS];
  logic [COUNT_W-1:0]         bin_tally [MAX_BINS];
  logic [COUNT_W-1:0]         miss_tally;
  ihc_out_t                   expected_q [$];
  int                         fail_total = 0;
  int                         queued = 0;

  assign mismatches = fail_total;
  assign pending    = queued;

  task automatic report_mismatch(input string msg);
    fail_total++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                             input logic [COUNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // The lowest-numbered enabled bin that holds the sample takes it.
  function automatic ihc_out_t classify_sample(input logic signed [SAMPLE_W-1:0] x);
    ihc_out_t                   res;
    logic                       found;
    logic [BIN_IDX_W-1:0]       idx;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    int                         b;
    found = 1'b0;
    idx   = '0;
    for (b = 0; b < NUM_BINS_DEF; b++) begin
      lo = bound_q[2*b];
      hi = bound_q[2*b+1];
      if (!found && hi >= lo && x >= lo && x <= hi) begin
        found = 1'b1;
        idx   = BIN_IDX_W'(b);
      end
    end
    if (found) begin
      if (bin_tally[idx] != '1) bin_tally[idx] = bin_tally[idx] + 1'b1;
    end else if (miss_tally != '1) begin
      miss_tally = miss_tally + 1'b1;
    end
    res.bin_hit    = idx;
    res.in_range   = found;
    res.count_bin0 = bin_tally[0];
    res.count_bin1 = bin_tally[1];
    res.count_bin2 = bin_tally[2];
    res.count_bin3 = bin_tally[3];
    res.miss_count = miss_tally;
    return res;
  endfunction

  always @(posedge clk) begin
    ihc_out_t want;
    int       r;
    if (rst) begin
      for (r = 0; r < NUM_REGS; r++) begin
        bound_q[r] = r[0] ? '1 : '0;
      end
      for (r = 0; r < MAX_BINS; r++) begin
        bin_tally[r] = '0;
      end
      miss_tally = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("bin_hit", out_data.bin_hit, want.bin_hit);
          check_field("in_range", out_data.in_range, want.in_range);
          check_field("count_bin0", out_data.count_bin0, want.count_bin0);
          check_field("count_bin1", out_data.count_bin1, want.count_bin1);
          check_field("count_bin2", out_data.count_bin2, want.count_bin2);
          check_field("count_bin3", out_data.count_bin3, want.count_bin3);
          check_field("miss_count", out_data.miss_count, want.miss_count);
        end
      end
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(), classify_sample(in_data.sample_value));
      end
      if (cfg_we && cfg_index < NUM_REGS) begin
        bound_q[cfg_index] = cfg_data;
      end
    end
    queued = expected_q.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the interval histogram counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ihc_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN0_LOW   = 4'd0,
    REG_BIN0_HIGH  = 4'd1,
    REG_BIN1_LOW   = 4'd2,
    REG_BIN1_HIGH  = 4'd3,
    REG_BIN2_LOW   = 4'd4,
    REG_BIN2_HIGH  = 4'd5,
    REG_BIN3_LOW   = 4'd6,
    REG_BIN3_HIGH  = 4'd7,
    REG_UNMAPPED_A = 4'd11,
    REG_UNMAPPED_B = 4'd15
  } cfg_reg_e;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_ITEMS    = 200;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_total;
  int                    results_pending;
  int                    idle_cycles = 0;
  logic                  tx_gaps = 1'b1;
  logic                  rx_gaps = 1'b1;
  logic                  long_hold_req = 1'b0;
  logic signed [SAMPLE_W-1:0] bin_lo [MAX_BINS];
  logic signed [SAMPLE_W-1:0] bin_hi [MAX_BINS];

  ihc_stream_if #(.payload_t(ihc_in_t))  sample_ch ();
  ihc_stream_if #(.payload_t(ihc_out_t)) result_ch ();

  interval_histogram_counter DUT (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ihc_result_checker u_result_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .in_data    (sample_ch.data),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_data   (result_ch.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatch_total),
    .pending    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Samples favor the configured bounds and their neighbors.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int                         b;
    int                         offs;
    logic signed [SAMPLE_W-1:0] bound_v;
    b       = $urandom_range(0, MAX_BINS - 1);
    offs    = $urandom_range(0, 2);
    bound_v = $urandom_range(0, 1) ? bin_lo[b] : bin_hi[b];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5, 6, 7: return SAMPLE_W'(int'(bound_v) + offs - 1);
      8:          return $urandom_range(0, 1) ? S_MIN : S_MAX;
      default:    return SAMPLE_W'(int'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  task automatic gen_bin(input int b);
    int lo;
    int hi;
    int span;
    lo = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 4))
      0: hi = int'($urandom_range(0, 65535)) - 32768;
      1: hi = lo;
      2: begin
        span = $urandom_range(0, 4000);
        hi   = (lo + span > 32767) ? 32767 : lo + span;
      end
      3: begin
        lo = -32768;
        hi = int'($urandom_range(0, 65535)) - 32768;
      end
      default: hi = 32767;
    endcase
    bin_lo[b] = SAMPLE_W'(lo);
    bin_hi[b] = SAMPLE_W'(hi);
  endtask

  task automatic set_bin(input int b, input logic signed [SAMPLE_W-1:0] lo,
                         input logic signed [SAMPLE_W-1:0] hi);
    bin_lo[b] = lo;
    bin_hi[b] = hi;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // The unmapped writes come last so that an aliasing decoder would corrupt a bound.
  task automatic program_bins();
    write_reg(REG_BIN0_LOW, bin_lo[0]);
    write_reg(REG_BIN0_HIGH, bin_hi[0]);
    write_reg(REG_BIN1_LOW, bin_lo[1]);
    write_reg(REG_BIN1_HIGH, bin_hi[1]);
    write_reg(REG_BIN2_LOW, bin_lo[2]);
    write_reg(REG_BIN2_HIGH, bin_hi[2]);
    write_reg(REG_BIN3_LOW, bin_lo[3]);
    write_reg(REG_BIN3_HIGH, bin_hi[3]);
    write_reg(REG_UNMAPPED_A, CFG_DATA_W'($urandom));
    write_reg(REG_UNMAPPED_B, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = rand_gap();
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid             <= 1'b1;
    sample_ch.data.sample_value <= v;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int gap;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        gap = rand_gap();
        result_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int phase;
    int b;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // All bins start disabled, so every sample is a miss.
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    wait_drained();

    // Overlapping bins, a bin down to the minimum and a single-value bin at the maximum.
    set_bin(0, -16'sd100, 16'sd100);
    set_bin(1, 16'sd50, 16'sd200);
    set_bin(2, S_MIN, -16'sd101);
    set_bin(3, S_MAX, S_MAX);
    program_bins();
    send_sample(S_MIN);
    send_sample(-16'sd101);
    send_sample(-16'sd100);
    send_sample(16'sd0);
    send_sample(16'sd100);
    send_sample(16'sd101);
    send_sample(16'sd200);
    send_sample(16'sd201);
    send_sample(S_MAX);
    send_sample(S_MAX - 16'sd1);
    wait_drained();

    // Bins with the high bound below the low bound match nothing.
    set_bin(0, 16'sd10, -16'sd10);
    set_bin(1, -16'sd5, 16'sd5);
    set_bin(2, 16'sd1, 16'sd0);
    set_bin(3, S_MIN, S_MAX);
    program_bins();
    send_sample(16'sd0);
    send_sample(16'sd10);
    send_sample(-16'sd10);
    send_sample(16'sd6);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 1) begin
        set_bin(0, S_MIN, S_MIN);
        set_bin(1, S_MAX, S_MAX);
        set_bin(2, S_MIN, S_MAX);
        set_bin(3, S_MAX, S_MIN);
      end else begin
        for (b = 0; b < MAX_BINS; b++) gen_bin(b);
      end
      program_bins();
      tx_gaps = (phase != RANDOM_PHASES - 1);
      rx_gaps = (phase != RANDOM_PHASES - 1);
      if (phase == 2) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      wait_drained();
    end

    if (mismatch_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
